// ===== design/tee_pkg.sv =====
// ============================================================================
// tee_pkg: shared types and constants for the text escape encoder
// Escape modes, the escape kinds passed from classifier to expander, the
// queue item and the character codes used by the escape sequences.
// ============================================================================
package tee_pkg;

    // Register map
    localparam int          PADDR_W         = 3;
    localparam int          PDATA_W         = 32;
    localparam logic        REG_ESCAPE_MODE = 1'b0;   // word index, paddr[2]

    // Default depth of the queue between the front and back sections
    localparam int          QUEUE_DEPTH     = 4;

    // Width of the byte index within one escape sequence (up to 6 bytes)
    localparam int          IDX_W           = 3;

    typedef enum logic [1:0] {
        MODE_XML   = 2'd0,
        MODE_TCL   = 2'd1,
        MODE_PLAIN = 2'd2,
        MODE_JSON  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        KIND_PASS,
        KIND_BS_SELF,
        KIND_BS_N,
        KIND_BS_T,
        KIND_BS_B,
        KIND_BS_R,
        KIND_XML_QUOT,
        KIND_XML_APOS,
        KIND_XML_LT,
        KIND_XML_GT,
        KIND_XML_AMP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic        str_end;
    } item_t;

    // Characters that get escaped
    localparam logic [7:0] CH_BKSP     = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_APOS     = 8'h27;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // Characters that appear inside escape sequences
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_B        = 8'h62;
    localparam logic [7:0] CH_G        = 8'h67;
    localparam logic [7:0] CH_L        = 8'h6C;
    localparam logic [7:0] CH_M        = 8'h6D;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_O        = 8'h6F;
    localparam logic [7:0] CH_P        = 8'h70;
    localparam logic [7:0] CH_Q        = 8'h71;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_S        = 8'h73;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_U        = 8'h75;

endpackage

// ===== design/tee_front.sv =====
// ============================================================================
// tee_front: input stage and classifier
// Accepts characters, decides which escape sequence each one needs under
// the current mode, and holds the result until the queue takes it.
// ============================================================================
module tee_front (
    input  logic            clk,
    input  logic            rst_n,
    input  tee_pkg::mode_t  mode,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      in_char,
    input  logic            string_end,
    output logic            q_wr_valid,
    input  logic            q_wr_ready,
    output tee_pkg::item_t  q_wr_item
);

    function automatic tee_pkg::kind_t classify(tee_pkg::mode_t m, logic [7:0] c);
        tee_pkg::kind_t k;
        k = tee_pkg::KIND_PASS;
        unique case (m)
            tee_pkg::MODE_XML:
            begin
                unique case (c)
                    tee_pkg::CH_QUOTE: k = tee_pkg::KIND_XML_QUOT;
                    tee_pkg::CH_APOS:  k = tee_pkg::KIND_XML_APOS;
                    tee_pkg::CH_LT:    k = tee_pkg::KIND_XML_LT;
                    tee_pkg::CH_GT:    k = tee_pkg::KIND_XML_GT;
                    tee_pkg::CH_AMP:   k = tee_pkg::KIND_XML_AMP;
                    default:           k = tee_pkg::KIND_PASS;
                endcase
            end
            tee_pkg::MODE_TCL:
            begin
                unique case (c)
                    tee_pkg::CH_QUOTE, tee_pkg::CH_DOLLAR, tee_pkg::CH_LBRACE,
                    tee_pkg::CH_RBRACE, tee_pkg::CH_LBRACKET, tee_pkg::CH_RBRACKET,
                    tee_pkg::CH_BSLASH: k = tee_pkg::KIND_BS_SELF;
                    tee_pkg::CH_LF:     k = tee_pkg::KIND_BS_N;
                    tee_pkg::CH_TAB:    k = tee_pkg::KIND_BS_T;
                    default:            k = tee_pkg::KIND_PASS;
                endcase
            end
            tee_pkg::MODE_JSON:
            begin
                unique case (c)
                    tee_pkg::CH_QUOTE, tee_pkg::CH_BSLASH,
                    tee_pkg::CH_SLASH:  k = tee_pkg::KIND_BS_SELF;
                    tee_pkg::CH_TAB:    k = tee_pkg::KIND_BS_T;
                    tee_pkg::CH_BKSP:   k = tee_pkg::KIND_BS_B;
                    tee_pkg::CH_LF:     k = tee_pkg::KIND_BS_N;
                    tee_pkg::CH_CR:     k = tee_pkg::KIND_BS_R;
                    default:            k = tee_pkg::KIND_PASS;
                endcase
            end
            default: k = tee_pkg::KIND_PASS;   // plain mode
        endcase
        return k;
    endfunction

    logic           fr_valid_reg;
    logic           fr_valid_next;
    tee_pkg::item_t fr_item_reg;
    tee_pkg::item_t fr_item_next;
    logic           take_in;

    // Stall only while the held item cannot move into the queue
    assign in_stall   = fr_valid_reg && !q_wr_ready;
    assign take_in    = in_valid && !in_stall;
    assign q_wr_valid = fr_valid_reg;
    assign q_wr_item  = fr_item_reg;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        fr_item_next  = fr_item_reg;
        if (take_in)
        begin
            fr_valid_next        = 1'b1;
            fr_item_next.kind    = classify(mode, in_char);
            fr_item_next.ch      = in_char;
            fr_item_next.str_end = string_end;
        end
        else if (q_wr_ready)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_item_reg <= fr_item_next;
    end

endmodule

// ===== design/tee_queue.sv =====
// ============================================================================
// tee_queue: small item queue
// Decouples the classifier from the expander so each side stalls on its own.
// ============================================================================
module tee_queue #(
    parameter int QueueDepth = tee_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  tee_pkg::item_t  wr_item,
    output logic            rd_valid,
    input  logic            rd_pop,
    output tee_pkg::item_t  rd_item
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

    tee_pkg::item_t  mem [QueueDepth];
    tee_pkg::item_t  rd_item_reg;
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = (count_reg != CntFull);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = rd_item_reg;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the slot; prefetch the next head, taking the incoming item when
    // it lands in the head slot this cycle
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
        if (do_wr && (wr_ptr_reg == rd_ptr_next))
        begin
            rd_item_reg <= wr_item;
        end
        else
        begin
            rd_item_reg <= mem[rd_ptr_next];
        end
    end

endmodule

// ===== design/tee_back.sv =====
// ============================================================================
// tee_back: escape sequence expander
// Takes one classified character at a time from the queue and emits its
// escape sequence one byte per cycle, while the output is not stalled, into the output register.
// ============================================================================
module tee_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  tee_pkg::item_t  q_item,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_char,
    output logic            run_last,
    output logic            string_done
);

    function automatic logic [tee_pkg::IDX_W-1:0] seq_len(tee_pkg::kind_t k);
        logic [tee_pkg::IDX_W-1:0] n;
        unique case (k)
            tee_pkg::KIND_PASS:     n = tee_pkg::IDX_W'(1);
            tee_pkg::KIND_BS_SELF,
            tee_pkg::KIND_BS_N,
            tee_pkg::KIND_BS_T,
            tee_pkg::KIND_BS_B,
            tee_pkg::KIND_BS_R:     n = tee_pkg::IDX_W'(2);
            tee_pkg::KIND_XML_QUOT,
            tee_pkg::KIND_XML_APOS: n = tee_pkg::IDX_W'(6);
            tee_pkg::KIND_XML_LT,
            tee_pkg::KIND_XML_GT:   n = tee_pkg::IDX_W'(4);
            tee_pkg::KIND_XML_AMP:  n = tee_pkg::IDX_W'(5);
            default:                n = tee_pkg::IDX_W'(1);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] seq_byte(tee_pkg::kind_t k, logic [7:0] c,
                                            logic [tee_pkg::IDX_W-1:0] idx);
        logic [7:0] b;
        logic [7:0] tail;
        unique case (k)
            tee_pkg::KIND_BS_SELF: tail = c;
            tee_pkg::KIND_BS_N:    tail = tee_pkg::CH_N;
            tee_pkg::KIND_BS_T:    tail = tee_pkg::CH_T;
            tee_pkg::KIND_BS_B:    tail = tee_pkg::CH_B;
            tee_pkg::KIND_BS_R:    tail = tee_pkg::CH_R;
            default:               tail = c;
        endcase
        b = c;
        unique case (k)
            tee_pkg::KIND_BS_SELF, tee_pkg::KIND_BS_N, tee_pkg::KIND_BS_T,
            tee_pkg::KIND_BS_B, tee_pkg::KIND_BS_R:
            begin
                b = (idx == '0) ? tee_pkg::CH_BSLASH : tail;
            end
            tee_pkg::KIND_XML_QUOT:
            begin
                unique case (idx)
                    3'd0:    b = tee_pkg::CH_AMP;
                    3'd1:    b = tee_pkg::CH_Q;
                    3'd2:    b = tee_pkg::CH_U;
                    3'd3:    b = tee_pkg::CH_O;
                    3'd4:    b = tee_pkg::CH_T;
                    default: b = tee_pkg::CH_SEMI;
                endcase
            end
            tee_pkg::KIND_XML_APOS:
            begin
                unique case (idx)
                    3'd0:    b = tee_pkg::CH_AMP;
                    3'd1:    b = tee_pkg::CH_A;
                    3'd2:    b = tee_pkg::CH_P;
                    3'd3:    b = tee_pkg::CH_O;
                    3'd4:    b = tee_pkg::CH_S;
                    default: b = tee_pkg::CH_SEMI;
                endcase
            end
            tee_pkg::KIND_XML_LT, tee_pkg::KIND_XML_GT:
            begin
                unique case (idx)
                    3'd0:    b = tee_pkg::CH_AMP;
                    3'd1:    b = (k == tee_pkg::KIND_XML_LT) ? tee_pkg::CH_L : tee_pkg::CH_G;
                    3'd2:    b = tee_pkg::CH_T;
                    default: b = tee_pkg::CH_SEMI;
                endcase
            end
            tee_pkg::KIND_XML_AMP:
            begin
                unique case (idx)
                    3'd0:    b = tee_pkg::CH_AMP;
                    3'd1:    b = tee_pkg::CH_A;
                    3'd2:    b = tee_pkg::CH_M;
                    3'd3:    b = tee_pkg::CH_P;
                    default: b = tee_pkg::CH_SEMI;
                endcase
            end
            default: b = c;
        endcase
        return b;
    endfunction

    logic                      cur_valid_reg;
    logic                      cur_valid_next;
    tee_pkg::item_t            cur_item_reg;
    tee_pkg::item_t            cur_item_next;
    logic [tee_pkg::IDX_W-1:0] idx_reg;
    logic [tee_pkg::IDX_W-1:0] idx_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [7:0]                out_char_reg;
    logic [7:0]                out_char_next;
    logic                      run_last_reg;
    logic                      run_last_next;
    logic                      string_done_reg;
    logic                      string_done_next;

    logic slot_free;
    logic emit;
    logic cur_last;
    logic cur_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = cur_valid_reg && slot_free;
    assign cur_last  = (idx_reg == seq_len(cur_item_reg.kind) - 1'b1);
    assign cur_free  = !cur_valid_reg || (emit && cur_last);
    assign q_pop     = cur_free && q_valid;

    // Working item: advance the byte index, drop the item after its last byte
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_item_next  = cur_item_reg;
        idx_next       = idx_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_item_next  = q_item;
            idx_next       = '0;
        end
        else if (emit && cur_last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_char_next    = out_char_reg;
        run_last_next    = run_last_reg;
        string_done_next = string_done_reg;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            out_char_next    = seq_byte(cur_item_reg.kind, cur_item_reg.ch, idx_reg);
            run_last_next    = cur_last;
            string_done_next = cur_last && cur_item_reg.str_end;
        end
        else if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_item_reg    <= cur_item_next;
        idx_reg         <= idx_next;
        out_char_reg    <= out_char_next;
        run_last_reg    <= run_last_next;
        string_done_reg <= string_done_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign run_last    = run_last_reg;
    assign string_done = string_done_reg;

endmodule

// ===== design/text_escape_encoder.sv =====
// ============================================================================
// text_escape_encoder: streaming string escaper (XML, Tcl, JSON, plain)
// Takes one character per item and emits its escaped form, one byte per
// output item, with the last byte of each character and of each string marked.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): in_char, string_end per item.
//   Output channel (out_valid / out_stall): out_char, run_last, string_done.
//   The escape_mode register (byte address 0, APB) selects xml, tcl, plain or
//   json; write it only while the encoder is empty. Reads return the mode.
//   The first byte of a character passes through the input register, queue,
//   expander and output register, in that order, after its item is accepted.
//   Throughput: one output byte per cycle while out_stall is low; a character
//   that expands to n bytes occupies the expander until its last byte is
//   emitted, so unescaped text flows at one item per cycle when not stalled.
//   A queue of QueueDepth items between classifier and expander absorbs the
//   expansion, so input keeps flowing while a long entity is being emitted.
//   When the receiver stalls, the output register holds its byte; the queue
//   fills, then in_stall rises. Reset empties every stage and sets xml mode.
// ============================================================================
module text_escape_encoder #(
    parameter int QueueDepth = tee_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  in_char,
    input  logic                        string_end,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_char,
    output logic                        run_last,
    output logic                        string_done,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tee_pkg::PADDR_W-1:0] paddr,
    input  logic [tee_pkg::PDATA_W-1:0] pwdata,
    output logic [tee_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    tee_pkg::mode_t mode_reg;
    tee_pkg::mode_t mode_next;
    logic           reg_sel;

    logic           q_wr_valid;
    logic           q_wr_ready;
    tee_pkg::item_t q_wr_item;
    logic           q_rd_valid;
    logic           q_pop;
    tee_pkg::item_t q_rd_item;

    // Configuration: single register, word index taken from paddr[2]
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == tee_pkg::REG_ESCAPE_MODE);

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            mode_next = tee_pkg::mode_t'(pwdata[1:0]);
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata[1:0] = mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tee_pkg::MODE_XML;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Front: accept and classify
    tee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_char    (in_char),
        .string_end (string_end),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_item  (q_wr_item)
    );

    // Queue between the two halves
    tee_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_item  (q_wr_item),
        .rd_valid (q_rd_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_rd_item)
    );

    // Back: expand into bytes
    tee_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_rd_valid),
        .q_pop       (q_pop),
        .q_item      (q_rd_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .string_done (string_done)
    );

    // End of string is only ever flagged on the last byte of a character
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> run_last)
        else $error("string_done without run_last");

    // The rest of a sequence follows directly after a middle byte is taken
    a_seq_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside an escape sequence");

    // Input backs up only when the queue is full
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !q_wr_ready && q_wr_valid)
        else $error("input stalled while queue has room");

    // Only non-empty queue may be popped
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_rd_valid)
        else $error("pop from empty queue");

endmodule
